// ===== src/rnl_pkg.sv =====
package rnl_pkg;

    // Field widths of the request and result items.
    localparam int CMD_WIDTH     = 5;
    localparam int ADDR_WIDTH    = 24;
    localparam int STATE_WIDTH   = 3;
    localparam int STATUS_WIDTH  = 3;
    localparam int MODEM_WIDTH   = 2;
    localparam int CAUSE_WIDTH   = 2;
    localparam int FLAGS_WIDTH   = 2;

    // Configuration port.
    localparam int CFG_WIDTH       = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESPONSE_TICKS   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODEM_TICKS      = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DISCONNECT_TICKS = 2'd2;

    localparam logic [CFG_WIDTH-1:0] RESPONSE_TICKS_RESET   = 16'd70;
    localparam logic [CFG_WIDTH-1:0] MODEM_TICKS_RESET      = 16'd70;
    localparam logic [CFG_WIDTH-1:0] DISCONNECT_TICKS_RESET = 16'd3;

    localparam int TIMER_WIDTH_DEFAULT = 16;

    // Classified events.
    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_TICK          = 5'd0,
        CMD_SEND_STATUS   = 5'd1,
        CMD_SETUP_CALL    = 5'd2,
        CMD_DISCONNECT    = 5'd3,
        CMD_RESET         = 5'd4,
        CMD_RADIO_REQUEST = 5'd5,
        CMD_LINK_READY    = 5'd6,
        CMD_LINK_FAIL     = 5'd7,
        CMD_RX_STATUS     = 5'd8,
        CMD_INCOMING_CALL = 5'd9,
        CMD_MSG_ACK_OK    = 5'd10,
        CMD_MSG_ACK_WAIT  = 5'd11,
        CMD_MSG_ACK_FAIL  = 5'd12,
        CMD_CLEARED       = 5'd13,
        CMD_SETUP_WAIT    = 5'd14,
        CMD_SETUP_OK      = 5'd15,
        CMD_SETUP_FAIL    = 5'd16,
        CMD_PROTOCOL_INFO = 5'd17,
        CMD_MODEM_OK      = 5'd18,
        CMD_MODEM_FAIL    = 5'd19,
        CMD_STATUS_READ   = 5'd20,
        CMD_NONE          = 5'd31
    } cmd_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        SS_IDLE    = 3'd0,
        SS_PENDING = 3'd1,
        SS_INSERV  = 3'd2,
        SS_INPROG  = 3'd3,
        SS_OK      = 3'd4,
        SS_FAIL    = 3'd5
    } request_status_t;

    typedef enum logic [MODEM_WIDTH-1:0] {
        MODEM_NONE    = 2'd0,
        MODEM_ENABLE  = 2'd1,
        MODEM_DISABLE = 2'd2
    } modem_ctrl_t;

    typedef enum logic [CAUSE_WIDTH-1:0] {
        CAUSE_NONE          = 2'd0,
        CAUSE_MAINTENANCE   = 2'd1,
        CAUSE_TIMEOUT       = 2'd2,
        CAUSE_MODEM_TIMEOUT = 2'd3
    } cause_t;

endpackage

// ===== src/rnl_if.sv =====
interface rnl_in_if import rnl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CMD_WIDTH-1:0]  command;
    logic [ADDR_WIDTH-1:0] address;
    logic                  modem_request;

    modport source (output valid, command, address, modem_request, input ready);
    modport sink   (input valid, command, address, modem_request, output ready);
endinterface

interface rnl_out_if import rnl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [STATE_WIDTH-1:0]  state_code;
    logic [STATUS_WIDTH-1:0] request_status;
    logic                    accepted;
    logic                    link_packet;
    logic                    forward_to_app;
    logic                    link_reset;
    logic [MODEM_WIDTH-1:0]  modem_control;
    logic [CAUSE_WIDTH-1:0]  disconnect_cause;
    logic [ADDR_WIDTH-1:0]   disconnect_address;
    logic [FLAGS_WIDTH-1:0]  network_flags;

    modport source (output valid, state_code, request_status, accepted, link_packet,
                    forward_to_app, link_reset, modem_control, disconnect_cause,
                    disconnect_address, network_flags, input ready);
    modport sink   (input valid, state_code, request_status, accepted, link_packet,
                    forward_to_app, link_reset, modem_control, disconnect_cause,
                    disconnect_address, network_flags, output ready);
endinterface

// ===== src/radio_network_layer_fsm.sv =====
// Radio network-layer controller. Each request on the item channel is one classified
// event (application request, link event, received message, modem result, status read
// or timer tick), and each produces exactly one result carrying the new protocol state,
// the send status, the action flags and any self-generated disconnect. The block takes
// one request per clock cycle as long as results are taken: a request is captured in an input
// register and the whole state update is a single layer of logic from that register into the
// result register. The response timer counts tick events, not clock cycles; loads wider than
// TIMER_WIDTH saturate to the largest count. Write the three tick registers only while
// no request is in flight.
module radio_network_layer_fsm import rnl_pkg::*; #(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    rnl_in_if.sink                     item,
    rnl_out_if.source                  result,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data
);

    // Timer loads are one bit wider than a register, to hold the doubled disconnect wait.
    localparam int LOAD_WIDTH = CFG_WIDTH + 1;
    localparam int SAT_WIDTH  = (TIMER_WIDTH > LOAD_WIDTH) ? TIMER_WIDTH : LOAD_WIDTH;

    typedef enum logic [STATE_WIDTH-1:0] {
        ST_DOWN   = 3'd0,
        ST_IDLE   = 3'd1,
        ST_MSGW   = 3'd2,
        ST_OUTW   = 3'd3,
        ST_ACTIVE = 3'd4,
        ST_DISW   = 3'd5
    } state_t;

    // Configuration registers.
    logic [CFG_WIDTH-1:0] response_ticks_reg;
    logic [CFG_WIDTH-1:0] modem_ticks_reg;
    logic [CFG_WIDTH-1:0] disconnect_ticks_reg;

    // Input stage.
    logic                  in_valid_reg;
    logic [CMD_WIDTH-1:0]  cmd_reg;
    logic [ADDR_WIDTH-1:0] addr_reg;
    logic                  mreq_reg;

    // Protocol state.
    state_t                 state_reg, state_next;
    request_status_t        send_reg, send_next;
    logic                   mcall_reg, mcall_next;
    logic                   msucc_reg, msucc_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic                   tpend_reg, tpend_next;
    logic [ADDR_WIDTH-1:0]  saddr_reg, saddr_next;
    logic [FLAGS_WIDTH-1:0] flags_reg, flags_next;

    // Result stage.
    logic                    out_valid_reg;
    logic [STATE_WIDTH-1:0]  res_state_reg;
    logic [STATUS_WIDTH-1:0] res_status_reg, res_status_next;
    logic                    res_acc_reg, res_acc_next;
    logic                    res_link_reg, res_link_next;
    logic                    res_fwd_reg, res_fwd_next;
    logic                    res_lrst_reg, res_lrst_next;
    modem_ctrl_t             res_modem_reg, res_modem_next;
    cause_t                  res_cause_reg, res_cause_next;
    logic [ADDR_WIDTH-1:0]   res_daddr_reg;
    logic [FLAGS_WIDTH-1:0]  res_flags_reg;

    logic out_free;
    logic step;
    logic [CMD_WIDTH-1:0] eff_cmd;
    logic req_ok;

    // Saturate a load value to the timer width.
    function automatic logic [TIMER_WIDTH-1:0] timer_sat(input logic [LOAD_WIDTH-1:0] value);
        logic [SAT_WIDTH-1:0] wide;
        logic [SAT_WIDTH-1:0] limit;
        wide  = SAT_WIDTH'(value);
        limit = SAT_WIDTH'({TIMER_WIDTH{1'b1}});
        if (wide > limit)
            return {TIMER_WIDTH{1'b1}};
        else
            return wide[TIMER_WIDTH-1:0];
    endfunction

    // The result register frees up when it is empty or being taken; the input register
    // then moves forward, so a new request can enter on every cycle.
    assign out_free   = !out_valid_reg || result.ready;
    assign step       = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;

    always_comb
    begin
        state_next      = state_reg;
        send_next       = send_reg;
        mcall_next      = mcall_reg;
        msucc_next      = msucc_reg;
        timer_next      = timer_reg;
        tpend_next      = tpend_reg;
        saddr_next      = saddr_reg;
        flags_next      = flags_reg;
        res_acc_next    = 1'b0;
        res_link_next   = 1'b0;
        res_fwd_next    = 1'b0;
        res_lrst_next   = 1'b0;
        res_modem_next  = MODEM_NONE;
        res_cause_next  = CAUSE_NONE;
        eff_cmd         = cmd_reg;
        req_ok          = 1'b0;

        // Application requests are checked first; a rejected one acts as no event.
        if (cmd_reg == CMD_SEND_STATUS || cmd_reg == CMD_SETUP_CALL ||
            cmd_reg == CMD_DISCONNECT || cmd_reg == CMD_RADIO_REQUEST)
        begin
            req_ok = (state_reg != ST_DOWN);
            if ((cmd_reg == CMD_SEND_STATUS || cmd_reg == CMD_SETUP_CALL) &&
                !(send_reg == SS_IDLE || send_reg == SS_OK || send_reg == SS_FAIL))
                req_ok = 1'b0;
            if (!req_ok)
            begin
                eff_cmd = CMD_NONE;
            end
            else
            begin
                res_acc_next = 1'b1;
                if (cmd_reg == CMD_SEND_STATUS || cmd_reg == CMD_SETUP_CALL)
                    send_next = SS_INSERV;
                mcall_next = (cmd_reg == CMD_SETUP_CALL) && mreq_reg;
                if (cmd_reg == CMD_SETUP_CALL && mreq_reg)
                    msucc_next = 1'b0;
            end
        end
        else if (cmd_reg == CMD_RESET)
        begin
            res_acc_next = 1'b1;
        end

        if (eff_cmd == CMD_TICK)
        begin
            if (timer_reg != '0)
            begin
                timer_next = timer_reg - TIMER_WIDTH'(1);
                if (timer_reg == TIMER_WIDTH'(1))
                begin
                    case (state_reg)
                        ST_MSGW, ST_OUTW:
                        begin
                            res_cause_next = mcall_reg ? CAUSE_MODEM_TIMEOUT : CAUSE_TIMEOUT;
                            res_link_next  = 1'b1;
                            send_next      = SS_FAIL;
                            state_next     = ST_IDLE;
                        end
                        ST_ACTIVE:
                        begin
                            tpend_next = 1'b1;
                        end
                        ST_DISW:
                        begin
                            send_next  = (mcall_reg && !msucc_reg) ? SS_FAIL : SS_OK;
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
        else if (eff_cmd == CMD_STATUS_READ)
        begin
            if (send_next == SS_OK || send_next == SS_FAIL)
                send_next = SS_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_DOWN:
                begin
                    if (eff_cmd == CMD_LINK_READY)
                    begin
                        flags_next = flags_reg | 2'b01;
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    case (eff_cmd)
                        CMD_RX_STATUS, CMD_INCOMING_CALL, CMD_CLEARED, CMD_PROTOCOL_INFO:
                            res_fwd_next = 1'b1;
                        CMD_SEND_STATUS, CMD_SETUP_CALL:
                        begin
                            saddr_next    = addr_reg;
                            res_link_next = 1'b1;
                            timer_next    = timer_sat({1'b0, response_ticks_reg});
                            tpend_next    = 1'b0;
                            state_next    = (eff_cmd == CMD_SEND_STATUS) ? ST_MSGW : ST_OUTW;
                        end
                        CMD_DISCONNECT, CMD_RADIO_REQUEST:
                            res_link_next = 1'b1;
                        CMD_RESET:
                        begin
                            res_lrst_next = 1'b1;
                            send_next     = SS_IDLE;
                            flags_next    = '0;
                            mcall_next    = 1'b0;
                            tpend_next    = 1'b0;
                            state_next    = ST_IDLE;
                        end
                        CMD_LINK_FAIL:
                        begin
                            send_next  = SS_FAIL;
                            flags_next = 2'b10;
                            state_next = ST_DOWN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_MSGW, ST_OUTW:
                begin
                    case (eff_cmd)
                        CMD_RX_STATUS:
                            res_fwd_next = 1'b1;
                        CMD_RADIO_REQUEST:
                            res_link_next = 1'b1;
                        CMD_MSG_ACK_WAIT:
                        begin
                            if (state_reg == ST_MSGW)
                            begin
                                send_next  = SS_INPROG;
                                timer_next = timer_sat({1'b0, response_ticks_reg});
                                tpend_next = 1'b0;
                            end
                        end
                        CMD_SETUP_WAIT:
                        begin
                            if (state_reg == ST_OUTW)
                            begin
                                timer_next = timer_sat({1'b0, response_ticks_reg});
                                tpend_next = 1'b0;
                            end
                        end
                        CMD_MSG_ACK_OK, CMD_MSG_ACK_FAIL:
                        begin
                            if (state_reg == ST_MSGW)
                            begin
                                timer_next = '0;
                                tpend_next = 1'b0;
                                send_next  = (eff_cmd == CMD_MSG_ACK_OK) ? SS_OK : SS_FAIL;
                                state_next = ST_IDLE;
                            end
                        end
                        CMD_SETUP_OK:
                        begin
                            if (state_reg == ST_OUTW)
                            begin
                                timer_next = '0;
                                tpend_next = 1'b0;
                                send_next  = SS_INPROG;
                                if (mcall_next)
                                begin
                                    res_modem_next = MODEM_ENABLE;
                                    timer_next     = timer_sat({1'b0, modem_ticks_reg});
                                end
                                state_next = ST_ACTIVE;
                            end
                        end
                        CMD_SETUP_FAIL:
                        begin
                            if (state_reg == ST_OUTW)
                            begin
                                timer_next = '0;
                                tpend_next = 1'b0;
                                send_next  = SS_FAIL;
                                state_next = ST_IDLE;
                            end
                        end
                        CMD_DISCONNECT:
                        begin
                            if (state_reg == ST_MSGW)
                            begin
                                timer_next = '0;
                                tpend_next = 1'b0;
                            end
                            res_link_next = 1'b1;
                            send_next     = SS_FAIL;
                            state_next    = ST_IDLE;
                        end
                        CMD_CLEARED:
                        begin
                            timer_next = '0;
                            tpend_next = 1'b0;
                            send_next  = SS_FAIL;
                            state_next = ST_IDLE;
                        end
                        CMD_RESET:
                        begin
                            // The call-setup wait leaves its timer running on a reset.
                            if (state_reg == ST_MSGW)
                                timer_next = '0;
                            res_lrst_next = 1'b1;
                            send_next     = SS_IDLE;
                            flags_next    = '0;
                            mcall_next    = 1'b0;
                            tpend_next    = 1'b0;
                            state_next    = ST_IDLE;
                        end
                        CMD_LINK_FAIL:
                        begin
                            timer_next = '0;
                            tpend_next = 1'b0;
                            send_next  = SS_FAIL;
                            flags_next = 2'b10;
                            state_next = ST_DOWN;
                        end
                        CMD_PROTOCOL_INFO:
                        begin
                            timer_next   = '0;
                            tpend_next   = 1'b0;
                            send_next    = SS_FAIL;
                            res_fwd_next = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_ACTIVE:
                begin
                    case (eff_cmd)
                        CMD_MODEM_OK, CMD_MODEM_FAIL:
                        begin
                            msucc_next     = (eff_cmd == CMD_MODEM_OK);
                            res_cause_next = CAUSE_MAINTENANCE;
                            res_link_next  = 1'b1;
                            timer_next     = timer_sat({disconnect_ticks_reg, 1'b0});
                            tpend_next     = 1'b0;
                            res_modem_next = MODEM_DISABLE;
                            state_next     = ST_DISW;
                        end
                        CMD_RX_STATUS:
                            res_fwd_next = 1'b1;
                        CMD_DISCONNECT, CMD_CLEARED:
                        begin
                            res_link_next  = (eff_cmd == CMD_DISCONNECT);
                            timer_next     = timer_sat({disconnect_ticks_reg, 1'b0});
                            tpend_next     = 1'b0;
                            res_modem_next = MODEM_DISABLE;
                            state_next     = ST_DISW;
                        end
                        CMD_RESET:
                        begin
                            res_lrst_next  = 1'b1;
                            send_next      = SS_IDLE;
                            flags_next     = '0;
                            mcall_next     = 1'b0;
                            tpend_next     = 1'b0;
                            state_next     = ST_IDLE;
                            res_modem_next = MODEM_DISABLE;
                        end
                        CMD_RADIO_REQUEST:
                            res_link_next = 1'b1;
                        CMD_LINK_FAIL:
                        begin
                            if (send_next != SS_OK && send_next != SS_FAIL)
                                send_next = SS_FAIL;
                            flags_next = 2'b10;
                            state_next = ST_DOWN;
                        end
                        CMD_PROTOCOL_INFO:
                        begin
                            timer_next = '0;
                            tpend_next = 1'b0;
                            if (send_next != SS_OK && send_next != SS_FAIL)
                                send_next = SS_FAIL;
                            res_modem_next = MODEM_DISABLE;
                            res_fwd_next   = 1'b1;
                            state_next     = ST_IDLE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_DISW:
                begin
                    if (eff_cmd == CMD_CLEARED)
                    begin
                        timer_next = timer_sat({1'b0, disconnect_ticks_reg});
                        tpend_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // A pending timeout only survives while the call stays active.
        if (state_next != ST_ACTIVE)
            tpend_next = 1'b0;

        // A status read reports the value it found, before clearing it.
        if (eff_cmd == CMD_STATUS_READ)
            res_status_next = send_reg;
        else
            res_status_next = send_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            response_ticks_reg   <= RESPONSE_TICKS_RESET;
            modem_ticks_reg      <= MODEM_TICKS_RESET;
            disconnect_ticks_reg <= DISCONNECT_TICKS_RESET;
            in_valid_reg         <= 1'b0;
            cmd_reg              <= '0;
            addr_reg             <= '0;
            mreq_reg             <= 1'b0;
            state_reg            <= ST_DOWN;
            send_reg             <= SS_IDLE;
            mcall_reg            <= 1'b0;
            msucc_reg            <= 1'b0;
            timer_reg            <= '0;
            tpend_reg            <= 1'b0;
            saddr_reg            <= '0;
            flags_reg            <= '0;
            out_valid_reg        <= 1'b0;
            res_state_reg        <= '0;
            res_status_reg       <= '0;
            res_acc_reg          <= 1'b0;
            res_link_reg         <= 1'b0;
            res_fwd_reg          <= 1'b0;
            res_lrst_reg         <= 1'b0;
            res_modem_reg        <= MODEM_NONE;
            res_cause_reg        <= CAUSE_NONE;
            res_daddr_reg        <= '0;
            res_flags_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RESPONSE_TICKS:   response_ticks_reg   <= cfg_data;
                    CFG_MODEM_TICKS:      modem_ticks_reg      <= cfg_data;
                    CFG_DISCONNECT_TICKS: disconnect_ticks_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (item.ready)
            begin
                in_valid_reg <= item.valid;
                cmd_reg      <= item.command;
                addr_reg     <= item.address;
                mreq_reg     <= item.modem_request;
            end

            if (out_free)
                out_valid_reg <= in_valid_reg;

            if (step)
            begin
                state_reg      <= state_next;
                send_reg       <= send_next;
                mcall_reg      <= mcall_next;
                msucc_reg      <= msucc_next;
                timer_reg      <= timer_next;
                tpend_reg      <= tpend_next;
                saddr_reg      <= saddr_next;
                flags_reg      <= flags_next;
                res_state_reg  <= state_next;
                res_status_reg <= res_status_next;
                res_acc_reg    <= res_acc_next;
                res_link_reg   <= res_link_next;
                res_fwd_reg    <= res_fwd_next;
                res_lrst_reg   <= res_lrst_next;
                res_modem_reg  <= res_modem_next;
                res_cause_reg  <= res_cause_next;
                res_daddr_reg  <= (res_cause_next != CAUSE_NONE) ? saddr_next : '0;
                res_flags_reg  <= flags_next;
            end
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.state_code         = res_state_reg;
    assign result.request_status     = res_status_reg;
    assign result.accepted           = res_acc_reg;
    assign result.link_packet        = res_link_reg;
    assign result.forward_to_app     = res_fwd_reg;
    assign result.link_reset         = res_lrst_reg;
    assign result.modem_control      = res_modem_reg;
    assign result.disconnect_cause   = res_cause_reg;
    assign result.disconnect_address = res_daddr_reg;
    assign result.network_flags      = res_flags_reg;

    // A generated disconnect always goes out to the data link.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_cause_reg != CAUSE_NONE) |-> res_link_reg)
        else $error("generated disconnect without link packet");

    // A pending timeout exists only in the active state.
    assert property (@(posedge clk) disable iff (!rst_n)
        tpend_reg |-> (state_reg == ST_ACTIVE))
        else $error("timeout pending outside the active state");

    // A network layer reset always leaves the block idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_lrst_reg) |-> (res_state_reg == ST_IDLE))
        else $error("layer reset did not end in idle");

    // The protocol state moves only when a request is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(state_reg))
        else $error("protocol state changed without a request");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Testbench for the radio network-layer controller.
//
// Every request on the event channel produces exactly one result. The bench
// keeps its own model of the six-state protocol machine, the send status, the
// modem-call marks, the tick-driven response timer and the stored address.
// Each accepted request is run through that model at the same clock edge.
// The result it predicts is queued and compared field by field with the
// block's next result.
//
// The run has a reset, then a short directed walk through the protocol, and
// then several register settings, each followed by a stretch of random
// requests. Random requests are mostly drawn from a menu that fits the
// current protocol state, so message waits, call setups, modem transfers and
// disconnect waits are all reached. The rest are arbitrary command codes, the
// unused ones among them.
module tb import rnl_pkg::*;;

    // Protocol states as the block reports them in state_code.
    typedef enum logic [STATE_WIDTH-1:0] {
        LS_DOWN      = 3'd0,
        LS_IDLE      = 3'd1,
        LS_MSG_WAIT  = 3'd2,
        LS_CALL_WAIT = 3'd3,
        LS_ACTIVE    = 3'd4,
        LS_DISC_WAIT = 3'd5
    } layer_state_t;

    typedef struct packed {
        logic [STATE_WIDTH-1:0]  state_code;
        logic [STATUS_WIDTH-1:0] request_status;
        logic                    accepted;
        logic                    link_packet;
        logic                    forward_to_app;
        logic                    link_reset;
        logic [MODEM_WIDTH-1:0]  modem_control;
        logic [CAUSE_WIDTH-1:0]  disconnect_cause;
        logic [ADDR_WIDTH-1:0]   disconnect_address;
        logic [FLAGS_WIDTH-1:0]  network_flags;
    } result_t;

    // One row of the directed walk. Where typed is set, the result in the
    // row is checked as written; otherwise the model's result is used.
    typedef struct {
        logic [CMD_WIDTH-1:0]  code;
        logic [ADDR_WIDTH-1:0] addr;
        logic                  mreq;
        bit                    typed;
        result_t               want;
    } walk_row_t;

    localparam int unsigned TICK_MAX = (1 << TIMER_WIDTH_DEFAULT) - 1;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_data;

    rnl_in_if  ev_ch ();
    rnl_out_if res_ch ();

    radio_network_layer_fsm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (ev_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The bench's own copy of the controller state and of its registers.
    layer_state_t                   ls_state;
    request_status_t                ls_send;
    logic                           ls_modem_call;
    logic                           ls_modem_ok;
    logic [TIMER_WIDTH_DEFAULT-1:0] ls_ticks;
    logic                           ls_timeout_seen;
    logic [ADDR_WIDTH-1:0]          ls_addr;
    logic [FLAGS_WIDTH-1:0]         ls_flags;
    int unsigned                    cfg_response;
    int unsigned                    cfg_modem;
    int unsigned                    cfg_disconnect;

    // Actions of the request being modeled, built up by the helpers below.
    result_t act;

    // Results still owed by the block, oldest first.
    result_t due_results[$];

    walk_row_t   walk[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned tx_calm;
    int unsigned rx_calm;
    int unsigned rx_stall;
    result_t     got_result;
    result_t     oldest;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // A plain safety net: the slowest correct run needs a small part of this.
    initial begin
        #10_000_000;
        $display("FAIL radio_network_layer_fsm");
        $finish;
    end

    // Length of one idle stretch: mostly short, now and then a long one.
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A timer load saturates at the largest count; any load clears a timeout
    // that was noted while the call was active.
    function automatic void arm_timer(input int unsigned n);
        ls_ticks = (n > TICK_MAX) ? TICK_MAX[TIMER_WIDTH_DEFAULT-1:0]
                                  : n[TIMER_WIDTH_DEFAULT-1:0];
        ls_timeout_seen = 1'b0;
    endfunction

    function automatic void stop_timer();
        ls_ticks = '0;
        ls_timeout_seen = 1'b0;
    endfunction

    function automatic void reset_layer();
        act.link_reset = 1'b1;
        ls_send = SS_IDLE;
        ls_flags = '0;
        ls_modem_call = 1'b0;
        ls_timeout_seen = 1'b0;
        ls_state = LS_IDLE;
    endfunction

    // Link failure drops the ready flag and raises the failed flag.
    function automatic void fail_link();
        ls_flags = 2'b10;
        ls_state = LS_DOWN;
    endfunction

    function automatic void enter_disc_wait(input int unsigned n);
        arm_timer(n);
        act.modem_control = MODEM_DISABLE;
        ls_state = LS_DISC_WAIT;
    endfunction

    // Applies one request to the model and returns the result it causes.
    function automatic result_t advance_layer(input logic [CMD_WIDTH-1:0] code,
                                              input logic [ADDR_WIDTH-1:0] addr,
                                              input logic mreq);
        logic [CMD_WIDTH-1:0]    cmd;
        logic                    take;
        logic                    msg_side;
        logic [STATUS_WIDTH-1:0] shown;
        layer_state_t            from;

        act = '0;
        cmd = code;

        // Application requests are screened first. A rejected one is then
        // treated like an unused code and changes nothing.
        if (cmd == CMD_SEND_STATUS || cmd == CMD_SETUP_CALL || cmd == CMD_DISCONNECT
            || cmd == CMD_RADIO_REQUEST) begin
            take = (ls_state != LS_DOWN);
            if (take && (cmd == CMD_SEND_STATUS || cmd == CMD_SETUP_CALL))
                take = (ls_send == SS_IDLE || ls_send == SS_OK || ls_send == SS_FAIL);
            if (!take) begin
                cmd = CMD_NONE;
            end
            else begin
                act.accepted = 1'b1;
                if (cmd == CMD_SEND_STATUS || cmd == CMD_SETUP_CALL)
                    ls_send = SS_INSERV;
                ls_modem_call = (cmd == CMD_SETUP_CALL) && mreq;
                if (cmd == CMD_SETUP_CALL && mreq)
                    ls_modem_ok = 1'b0;
            end
        end
        else if (cmd == CMD_RESET) begin
            act.accepted = 1'b1;
        end

        shown = ls_send;
        from = ls_state;
        msg_side = (from == LS_MSG_WAIT);

        if (cmd == CMD_TICK) begin
            if (ls_ticks != 0) begin
                ls_ticks = ls_ticks - 1'b1;
                if (ls_ticks == 0) begin
                    case (ls_state)
                        LS_MSG_WAIT, LS_CALL_WAIT: begin
                            act.disconnect_cause = ls_modem_call ? CAUSE_MODEM_TIMEOUT
                                                                 : CAUSE_TIMEOUT;
                            act.link_packet = 1'b1;
                            ls_send = SS_FAIL;
                            ls_state = LS_IDLE;
                        end
                        LS_ACTIVE: ls_timeout_seen = 1'b1;
                        LS_DISC_WAIT: begin
                            ls_send = (ls_modem_call && !ls_modem_ok) ? SS_FAIL : SS_OK;
                            ls_state = LS_IDLE;
                        end
                        default: ;
                    endcase
                end
            end
        end
        else if (cmd == CMD_STATUS_READ) begin
            if (ls_send == SS_OK || ls_send == SS_FAIL)
                ls_send = SS_IDLE;
        end
        else begin
            case (from)
                LS_DOWN: begin
                    if (cmd == CMD_LINK_READY) begin
                        ls_flags = ls_flags | 2'b01;
                        ls_state = LS_IDLE;
                    end
                end
                LS_IDLE: begin
                    case (cmd)
                        CMD_RX_STATUS, CMD_INCOMING_CALL, CMD_CLEARED, CMD_PROTOCOL_INFO:
                            act.forward_to_app = 1'b1;
                        CMD_SEND_STATUS, CMD_SETUP_CALL: begin
                            ls_addr = addr;
                            act.link_packet = 1'b1;
                            arm_timer(cfg_response);
                            ls_state = (cmd == CMD_SEND_STATUS) ? LS_MSG_WAIT : LS_CALL_WAIT;
                        end
                        CMD_DISCONNECT, CMD_RADIO_REQUEST: act.link_packet = 1'b1;
                        CMD_RESET: reset_layer();
                        CMD_LINK_FAIL: begin
                            ls_send = SS_FAIL;
                            fail_link();
                        end
                        default: ;
                    endcase
                end
                LS_MSG_WAIT, LS_CALL_WAIT: begin
                    case (cmd)
                        CMD_RX_STATUS: act.forward_to_app = 1'b1;
                        CMD_RADIO_REQUEST: act.link_packet = 1'b1;
                        CMD_MSG_ACK_WAIT: begin
                            if (msg_side) begin
                                ls_send = SS_INPROG;
                                arm_timer(cfg_response);
                            end
                        end
                        CMD_SETUP_WAIT: if (!msg_side) arm_timer(cfg_response);
                        CMD_MSG_ACK_OK, CMD_MSG_ACK_FAIL: begin
                            if (msg_side) begin
                                stop_timer();
                                ls_send = (cmd == CMD_MSG_ACK_OK) ? SS_OK : SS_FAIL;
                                ls_state = LS_IDLE;
                            end
                        end
                        CMD_SETUP_OK: begin
                            if (!msg_side) begin
                                stop_timer();
                                ls_send = SS_INPROG;
                                if (ls_modem_call) begin
                                    act.modem_control = MODEM_ENABLE;
                                    arm_timer(cfg_modem);
                                end
                                ls_state = LS_ACTIVE;
                            end
                        end
                        CMD_SETUP_FAIL: begin
                            if (!msg_side) begin
                                stop_timer();
                                ls_send = SS_FAIL;
                                ls_state = LS_IDLE;
                            end
                        end
                        CMD_DISCONNECT: begin
                            // Only the message wait stops the timer here.
                            if (msg_side)
                                stop_timer();
                            act.link_packet = 1'b1;
                            ls_send = SS_FAIL;
                            ls_state = LS_IDLE;
                        end
                        CMD_CLEARED: begin
                            stop_timer();
                            ls_send = SS_FAIL;
                            ls_state = LS_IDLE;
                        end
                        CMD_RESET: begin
                            if (msg_side)
                                stop_timer();
                            reset_layer();
                        end
                        CMD_LINK_FAIL: begin
                            stop_timer();
                            ls_send = SS_FAIL;
                            fail_link();
                        end
                        CMD_PROTOCOL_INFO: begin
                            stop_timer();
                            ls_send = SS_FAIL;
                            act.forward_to_app = 1'b1;
                            ls_state = LS_IDLE;
                        end
                        default: ;
                    endcase
                end
                LS_ACTIVE: begin
                    case (cmd)
                        CMD_MODEM_OK, CMD_MODEM_FAIL: begin
                            ls_modem_ok = (cmd == CMD_MODEM_OK);
                            act.disconnect_cause = CAUSE_MAINTENANCE;
                            act.link_packet = 1'b1;
                            enter_disc_wait(2 * cfg_disconnect);
                        end
                        CMD_RX_STATUS: act.forward_to_app = 1'b1;
                        CMD_DISCONNECT: begin
                            act.link_packet = 1'b1;
                            enter_disc_wait(2 * cfg_disconnect);
                        end
                        CMD_CLEARED: enter_disc_wait(2 * cfg_disconnect);
                        CMD_RESET: begin
                            reset_layer();
                            act.modem_control = MODEM_DISABLE;
                        end
                        CMD_RADIO_REQUEST: act.link_packet = 1'b1;
                        CMD_LINK_FAIL: begin
                            if (ls_send != SS_OK && ls_send != SS_FAIL)
                                ls_send = SS_FAIL;
                            fail_link();
                        end
                        CMD_PROTOCOL_INFO: begin
                            stop_timer();
                            if (ls_send != SS_OK && ls_send != SS_FAIL)
                                ls_send = SS_FAIL;
                            act.modem_control = MODEM_DISABLE;
                            act.forward_to_app = 1'b1;
                            ls_state = LS_IDLE;
                        end
                        default: ;
                    endcase
                end
                LS_DISC_WAIT: begin
                    // A clear restarts the wait with the undoubled count.
                    if (cmd == CMD_CLEARED)
                        arm_timer(cfg_disconnect);
                end
                default: ;
            endcase
        end

        if (ls_state != LS_ACTIVE)
            ls_timeout_seen = 1'b0;

        act.state_code = ls_state;
        // A status read shows the value it read, before ok or fail is cleared.
        act.request_status = (cmd == CMD_STATUS_READ) ? shown : ls_send;
        act.disconnect_address = (act.disconnect_cause != CAUSE_NONE) ? ls_addr : '0;
        act.network_flags = ls_flags;
        return act;
    endfunction

    // Offers one request on the event channel. It is entered at a falling
    // edge and returns at the falling edge after the request was taken.
    task automatic offer_event(input logic [CMD_WIDTH-1:0] code,
                               input logic [ADDR_WIDTH-1:0] addr,
                               input logic mreq,
                               input bit typed,
                               input result_t want);
        int unsigned gap;
        result_t     predicted;

        if (tx_calm > 0)
            tx_calm--;
        else if ($urandom_range(0, 63) == 0)
            tx_calm = $urandom_range(20, 60);

        // While the result side is held off, keep offering so the block backs up.
        gap = 0;
        if (tx_calm == 0 && hold_left == 0 && $urandom_range(0, 99) < 30)
            gap = idle_len();
        if (gap > 0) begin
            ev_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end

        ev_ch.command = code;
        ev_ch.address = addr;
        ev_ch.modem_request = mreq;
        ev_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (ev_ch.ready !== 1'b1);

        predicted = advance_layer(code, addr, mreq);
        due_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Register writes happen at falling edges, only while nothing is in flight.
    task automatic set_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                input int unsigned value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value[CFG_WIDTH-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_RESPONSE_TICKS:   cfg_response = value;
            CFG_MODEM_TICKS:      cfg_modem = value;
            CFG_DISCONNECT_TICKS: cfg_disconnect = value;
            default: ;
        endcase
    endtask

    task automatic report_field(input string name, input logic [ADDR_WIDTH-1:0] want,
                                input logic [ADDR_WIDTH-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result side: a random ready pattern with stretches of none, plus one
    // long hold-off once the run is well under way. The hold-off is counted
    // here in cycles so the sender keeps offering requests while it lasts.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                res_ch.ready = 1'b0;
                hold_left--;
            end
            else if (!hold_done && results_seen >= 400) begin
                hold_done = 1'b1;
                hold_left = 249;
                res_ch.ready = 1'b0;
            end
            else if (rx_stall > 0) begin
                res_ch.ready = 1'b0;
                rx_stall--;
            end
            else begin
                if (rx_calm > 0)
                    rx_calm--;
                else if ($urandom_range(0, 127) == 0)
                    rx_calm = $urandom_range(50, 200);
                if (rx_calm == 0 && $urandom_range(0, 99) < 25) begin
                    rx_stall = idle_len() - 1;
                    res_ch.ready = 1'b0;
                end
                else begin
                    res_ch.ready = 1'b1;
                end
            end
        end
    end

    // Every result taken is checked against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            results_seen++;
            got_result = '{res_ch.state_code, res_ch.request_status, res_ch.accepted,
                           res_ch.link_packet, res_ch.forward_to_app,
                           res_ch.link_reset, res_ch.modem_control,
                           res_ch.disconnect_cause, res_ch.disconnect_address,
                           res_ch.network_flags};
            if (due_results.size() == 0) begin
                $display("%0t ns: result with none expected, got %h", $time, got_result);
                mismatches++;
            end
            else begin
                oldest = due_results.pop_front();
                report_field("state_code", oldest.state_code, got_result.state_code);
                report_field("request_status", oldest.request_status,
                             got_result.request_status);
                report_field("accepted", oldest.accepted, got_result.accepted);
                report_field("link_packet", oldest.link_packet,
                             got_result.link_packet);
                report_field("forward_to_app", oldest.forward_to_app,
                             got_result.forward_to_app);
                report_field("link_reset", oldest.link_reset, got_result.link_reset);
                report_field("modem_control", oldest.modem_control,
                             got_result.modem_control);
                report_field("disconnect_cause", oldest.disconnect_cause,
                             got_result.disconnect_cause);
                report_field("disconnect_address", oldest.disconnect_address,
                             got_result.disconnect_address);
                report_field("network_flags", oldest.network_flags,
                             got_result.network_flags);
            end
        end
    end

    initial begin
        int unsigned           settings[6][3];
        int unsigned           phase_len[6];
        cmd_t                  menu[$];
        logic [CMD_WIDTH-1:0]  code;
        logic [ADDR_WIDTH-1:0] addr;
        logic                  mreq;

        // Every input is known from the first instant.
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_RESPONSE_TICKS;
        cfg_data = '0;
        ev_ch.valid = 1'b0;
        ev_ch.command = CMD_TICK;
        ev_ch.address = '0;
        ev_ch.modem_request = 1'b0;

        mismatches = 0;
        results_seen = 0;
        hold_left = 0;
        hold_done = 1'b0;
        tx_calm = 0;
        rx_calm = 0;
        rx_stall = 0;

        // Model state after reset.
        ls_state = LS_DOWN;
        ls_send = SS_IDLE;
        ls_modem_call = 1'b0;
        ls_modem_ok = 1'b0;
        ls_ticks = '0;
        ls_timeout_seen = 1'b0;
        ls_addr = '0;
        ls_flags = '0;
        cfg_response = RESPONSE_TICKS_RESET;
        cfg_modem = MODEM_TICKS_RESET;
        cfg_disconnect = DISCONNECT_TICKS_RESET;

        // Register settings per phase: reset values, all at the minimum, all
        // at the maximum, then a few short counts so that timeouts come often.
        // Phase four is drawn at random below.
        settings = '{'{70, 70, 3}, '{1, 1, 1}, '{65535, 65535, 65535},
                     '{3, 2, 2}, '{1, 1, 1}, '{5, 3, 1}};
        phase_len = '{150, 150, 100, 150, 150, 150};

        // The directed walk. The first rows follow reset in the link-down
        // state, where every result can be written down directly: a rejected
        // request, a reset that is taken but does nothing, link ready, and an
        // unused command code.
        walk.push_back('{CMD_SEND_STATUS, 24'hFFFFFF, 1'b0, 1'b1,
                         '{LS_DOWN, SS_IDLE, 1'b0, 1'b0, 1'b0, 1'b0,
                           MODEM_NONE, CAUSE_NONE, 24'h0, 2'b00}});
        walk.push_back('{CMD_RESET, 24'h0, 1'b0, 1'b1,
                         '{LS_DOWN, SS_IDLE, 1'b1, 1'b0, 1'b0, 1'b0,
                           MODEM_NONE, CAUSE_NONE, 24'h0, 2'b00}});
        walk.push_back('{CMD_LINK_READY, 24'h0, 1'b0, 1'b1,
                         '{LS_IDLE, SS_IDLE, 1'b0, 1'b0, 1'b0, 1'b0,
                           MODEM_NONE, CAUSE_NONE, 24'h0, 2'b01}});
        walk.push_back('{CMD_NONE, 24'hFFFFFF, 1'b1, 1'b1,
                         '{LS_IDLE, SS_IDLE, 1'b0, 1'b0, 1'b0, 1'b0,
                           MODEM_NONE, CAUSE_NONE, 24'h0, 2'b01}});
        // A status message with a busy request and an intermediate ack.
        walk.push_back('{CMD_RX_STATUS, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_SEND_STATUS, 24'h000000, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_SETUP_CALL, 24'h123456, 1'b1, 1'b0, '0});
        walk.push_back('{CMD_MSG_ACK_WAIT, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_MSG_ACK_OK, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_STATUS_READ, 24'h0, 1'b0, 1'b0, '0});
        // A modem call through setup to a finished transfer and the wait
        // for the disconnect to settle.
        walk.push_back('{CMD_SETUP_CALL, 24'hFFFFFF, 1'b1, 1'b0, '0});
        walk.push_back('{CMD_SETUP_WAIT, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_SETUP_OK, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_RX_STATUS, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_RADIO_REQUEST, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_MODEM_OK, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_CLEARED, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_TICK, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_TICK, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_TICK, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_STATUS_READ, 24'h0, 1'b0, 1'b0, '0});
        // A voice call dropped by protocol info, a reset, and a link failure.
        walk.push_back('{CMD_SETUP_CALL, 24'h5A5A5A, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_PROTOCOL_INFO, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_RESET, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_LINK_FAIL, 24'h0, 1'b0, 1'b0, '0});
        walk.push_back('{CMD_LINK_READY, 24'h0, 1'b0, 1'b0, '0});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int p = 0; p < 6; p++) begin
            if (p == 0) begin
                foreach (walk[i])
                    offer_event(walk[i].code, walk[i].addr, walk[i].mreq,
                                walk[i].typed, walk[i].want);
            end
            else begin
                // The sender pauses until every result has come back, and waits a
                // little longer before the registers change.
                ev_ch.valid = 1'b0;
                while (due_results.size() != 0)
                    @(negedge clk);
                repeat (4) @(negedge clk);
                if (p == 4) begin
                    settings[4][0] = $urandom_range(1, 10);
                    settings[4][1] = $urandom_range(1, 10);
                    settings[4][2] = $urandom_range(1, 10);
                end
                set_register(CFG_RESPONSE_TICKS, settings[p][0]);
                set_register(CFG_MODEM_TICKS, settings[p][1]);
                set_register(CFG_DISCONNECT_TICKS, settings[p][2]);
            end

            for (int k = 0; k < phase_len[p]; k++) begin
                // Most requests fit the protocol state, so that calls and
                // messages run their course; the rest are arbitrary codes.
                case (ls_state)
                    LS_DOWN:
                        menu = '{CMD_LINK_READY, CMD_LINK_READY, CMD_LINK_READY,
                                 CMD_SEND_STATUS, CMD_RESET, CMD_STATUS_READ,
                                 CMD_TICK, CMD_DISCONNECT};
                    LS_IDLE:
                        menu = '{CMD_SEND_STATUS, CMD_SEND_STATUS, CMD_SETUP_CALL,
                                 CMD_SETUP_CALL, CMD_SETUP_CALL, CMD_STATUS_READ,
                                 CMD_STATUS_READ, CMD_RX_STATUS, CMD_INCOMING_CALL,
                                 CMD_CLEARED, CMD_PROTOCOL_INFO, CMD_DISCONNECT,
                                 CMD_RADIO_REQUEST, CMD_RESET, CMD_LINK_FAIL, CMD_TICK};
                    LS_MSG_WAIT:
                        menu = '{CMD_TICK, CMD_TICK, CMD_TICK, CMD_TICK,
                                 CMD_MSG_ACK_OK, CMD_MSG_ACK_WAIT, CMD_MSG_ACK_FAIL,
                                 CMD_RX_STATUS, CMD_RADIO_REQUEST, CMD_DISCONNECT,
                                 CMD_CLEARED, CMD_RESET, CMD_LINK_FAIL,
                                 CMD_PROTOCOL_INFO, CMD_STATUS_READ};
                    LS_CALL_WAIT:
                        menu = '{CMD_TICK, CMD_TICK, CMD_TICK, CMD_TICK,
                                 CMD_SETUP_WAIT, CMD_SETUP_OK, CMD_SETUP_OK,
                                 CMD_SETUP_OK, CMD_SETUP_FAIL, CMD_RX_STATUS,
                                 CMD_DISCONNECT, CMD_CLEARED, CMD_RESET,
                                 CMD_LINK_FAIL, CMD_PROTOCOL_INFO};
                    LS_ACTIVE:
                        menu = '{CMD_TICK, CMD_TICK, CMD_TICK, CMD_MODEM_OK,
                                 CMD_MODEM_OK, CMD_MODEM_FAIL, CMD_RX_STATUS,
                                 CMD_DISCONNECT, CMD_CLEARED, CMD_RESET,
                                 CMD_RADIO_REQUEST, CMD_LINK_FAIL, CMD_PROTOCOL_INFO,
                                 CMD_STATUS_READ};
                    default:
                        menu = '{CMD_TICK, CMD_TICK, CMD_TICK, CMD_TICK, CMD_TICK,
                                 CMD_CLEARED, CMD_RESET, CMD_STATUS_READ,
                                 CMD_SEND_STATUS};
                endcase
                if ($urandom_range(0, 99) < 12)
                    code = CMD_WIDTH'($urandom_range(0, 31));
                else
                    code = menu[$urandom_range(0, menu.size() - 1)];
                case ($urandom_range(0, 9))
                    0:       addr = '0;
                    1:       addr = '1;
                    default: addr = ADDR_WIDTH'($urandom());
                endcase
                mreq = 1'($urandom_range(0, 1));
                offer_event(code, addr, mreq, 1'b0, '0);
            end
        end

        // All requests are in: wait for the last results, then a little
        // longer in case something extra comes out.
        ev_ch.valid = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("PASS radio_network_layer_fsm");
        else
            $display("FAIL radio_network_layer_fsm");
        $finish;
    end

endmodule
